// ===== rtl/clx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, token codes and character class functions for the calculator lexer.
// Depends on nothing; every other file in rtl imports it.
package clx_pkg;

	localparam int DATA_W = 8;
	localparam int FIELD_W = 8;
	localparam int KIND_W = 3;
	localparam int M_TDATA_W = 24;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_END = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDENT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OPEN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd5;
	localparam logic [KIND_W-1:0] KIND_ILLEGAL = 3'd6;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] blanks;
		logic               last;
	} clx_res_t;

	typedef struct packed {
		logic     v0;
		logic     v1;
		clx_res_t r0;
		clx_res_t r1;
	} clx_push_t;

	function automatic logic is_digit(input logic [DATA_W-1:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [DATA_W-1:0] c);
		return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
	endfunction

	function automatic logic is_symbol(input logic [DATA_W-1:0] c);
		return c inside {8'h21, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2f, 8'h3a, 8'h3c,
			8'h3d, 8'h3e, 8'h7e, 8'h5f, 8'h5e, 8'h2b, 8'h2d};
	endfunction

	function automatic logic is_blank(input logic [DATA_W-1:0] c);
		return c inside {8'h20, 8'h09};
	endfunction

endpackage

// ===== rtl/clx_core.sv =====
`timescale 1ns / 1ps
// Lexer state and byte classification: turns one registered byte into up to two results.
// Depends on clx_pkg.
module clx_core
	import clx_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [DATA_W-1:0] byte_s1,
	output clx_push_t         push
);

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUMBER = 2'd1;
	localparam logic [1:0] MODE_IDENT = 2'd2;

	logic [1:0]            mode_q, mode_d;
	logic [COUNT_BITS-1:0] blank_q, blank_d;
	logic [COUNT_BITS-1:0] tblank_q, tblank_d;
	logic [COUNT_BITS-1:0] run_q, run_d;

	logic           running, cont, starts, single;
	clx_res_t       run_res, single_res;
	logic [KIND_W-1:0] single_kind;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	always_comb begin
		running = (mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT);
		if (mode_q == MODE_NUMBER) begin
			cont = is_digit(byte_s1) || (byte_s1 == 8'h2e);
		end else begin
			cont = is_alpha(byte_s1) || is_digit(byte_s1) || is_symbol(byte_s1);
		end
		starts = is_digit(byte_s1) || is_alpha(byte_s1) || is_symbol(byte_s1);

		case (byte_s1)
			8'h00:   single_kind = KIND_END;
			8'h28:   single_kind = KIND_OPEN;
			8'h29:   single_kind = KIND_CLOSE;
			8'h0a:   single_kind = KIND_NEWLINE;
			default: single_kind = KIND_ILLEGAL;
		endcase

		run_res.kind = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
		run_res.length = FIELD_W'(run_q);
		run_res.blanks = FIELD_W'(tblank_q);
		run_res.last = 1'b0;

		single_res.kind = single_kind;
		single_res.length = (single_kind == KIND_END) ? '0 : FIELD_W'(1);
		single_res.blanks = FIELD_W'(blank_q);
		single_res.last = 1'b1;

		mode_d = mode_q;
		blank_d = blank_q;
		tblank_d = tblank_q;
		run_d = run_q;
		single = 1'b0;
		push = '0;

		if (running && cont) begin
			run_d = sat_inc(run_q);
		end else begin
			if (running) begin
				mode_d = MODE_IDLE;
				run_d = '0;
				tblank_d = '0;
			end
			if (is_blank(byte_s1)) begin
				blank_d = sat_inc(blank_q);
			end else if (starts) begin
				mode_d = is_digit(byte_s1) ? MODE_NUMBER : MODE_IDENT;
				tblank_d = blank_q;
				run_d = COUNT_BITS'(1);
				blank_d = '0;
			end else begin
				single = 1'b1;
				blank_d = '0;
			end
		end

		if (adv) begin
			if (running && !cont) begin
				push.v0 = 1'b1;
				push.r0 = run_res;
				push.r0.last = !single;
				push.v1 = single;
				push.r1 = single_res;
			end else if (single) begin
				push.v0 = 1'b1;
				push.r0 = single_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			blank_q <= '0;
			tblank_q <= '0;
			run_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			blank_q <= blank_d;
			tblank_q <= tblank_d;
			run_q <= run_d;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && !push.r0.last && push.r1.last))
		else $error("two results not ordered run token then terminator");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.kind == KIND_END) ||
		(push.v1 && push.r1.kind == KIND_END) |=> (mode_q == MODE_IDLE && blank_q == '0))
		else $error("end token did not leave the lexer idle");

	a_run_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && running && cont) |-> (!push.v0 && !push.v1))
		else $error("continuing byte produced a result");

endmodule

// ===== rtl/clx_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on clx_pkg.
module clx_fifo
	import clx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  clx_push_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output clx_res_t  out_res
);

	clx_res_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wp1;
	logic             pop;

	assign wp1 = wp_q + PTR_W'(1);
	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res = mem_q[rp_q];
	assign room = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wp1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PTR_W'(push.v0) + PTR_W'(push.v1);
			rp_q <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> (cnt_q <= CNT_W'(FIFO_DEPTH - 2)))
		else $error("result pushed without room reserved");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule

// ===== rtl/calc_token_lexer.sv =====
`timescale 1ns / 1ps
// Calculator lexer top level: input register, lexer core and result queue.
// Depends on clx_pkg, clx_core and clx_fifo.
// Each result passes from the input register into the result queue, which offers it;
// a byte waits in the input register while the queue lacks room. Throughput: one byte
// per cycle while the queue has room; a byte that ends a running token and makes its own
// token yields two results, which leave over two output transfers from a four-entry queue.
// Reset clears the lexer state, the input register valid flag and the queue.
module calc_token_lexer
	import clx_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // [7:0] text_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] token_kind, [10:3] token_length,
	                                        // [18:11] leading_blanks, [23:19] zero
	output logic                 m_tlast    // last_of_run
);

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              room, adv;
	clx_push_t         push;
	clx_res_t          out_res;

	assign adv = valid_s1 && room;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	clx_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.byte_s1(byte_s1),
		.push   (push)
	);

	clx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {5'd0, out_res.blanks, out_res.length, out_res.kind};
	assign m_tlast = out_res.last;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for calc_token_lexer: streams text bytes, predicts each token
// and compares it with the output stream. Depends on clx_pkg and the lexer RTL.
module testbench;
	import clx_pkg::*;

	localparam int COUNT_BITS = 8;
	localparam logic [7:0] COUNT_MAX = 8'((1 << COUNT_BITS) - 1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 1050;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_DOT = 8'h2e;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_NUMBER,
		SCAN_IDENT
	} scan_e;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	scan_e      scan_mode;
	logic [7:0] blank_cnt;
	logic [7:0] tok_blanks;
	logic [7:0] run_len;
	clx_res_t   token_q[$];

	int  cycles;
	int  bytes_sent;
	int  tokens_seen;
	int  fail_count;
	int  burst_left;
	bit  steady;
	bit  hold_req;

	calc_token_lexer #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit chr_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic bit chr_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic bit chr_symbol(input logic [7:0] c);
		case (c)
			"!", "$", "%", "&", "*", "/", ":", "<", "=", ">", "~", "_", "^", "+", "-":
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == COUNT_MAX) ? v : v + 8'd1;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range(8'h30, 8'h39));
	endfunction

	function automatic logic [7:0] rand_alpha();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h61, 8'h7a));
		return 8'($urandom_range(8'h41, 8'h5a));
	endfunction

	function automatic logic [7:0] rand_symbol();
		case ($urandom_range(0, 14))
			0: return "!";
			1: return "$";
			2: return "%";
			3: return "&";
			4: return "*";
			5: return "/";
			6: return ":";
			7: return "<";
			8: return "=";
			9: return ">";
			10: return "~";
			11: return "_";
			12: return "^";
			13: return "+";
			default: return "-";
		endcase
	endfunction

	function automatic logic [7:0] rand_ident_char();
		case ($urandom_range(0, 2))
			0: return rand_alpha();
			1: return rand_digit();
			default: return rand_symbol();
		endcase
	endfunction

	function automatic logic [7:0] rand_blank();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	// Works out the tokens one accepted byte produces and queues them in output order.
	task automatic lex_byte(input logic [7:0] c);
		clx_res_t res[2];
		int       n;
		bit       cont;
		logic [KIND_W-1:0] kind;
		n = 0;
		if (scan_mode != SCAN_IDLE) begin
			if (scan_mode == SCAN_NUMBER)
				cont = chr_digit(c) || c == CH_DOT;
			else
				cont = chr_alpha(c) || chr_digit(c) || chr_symbol(c);
			if (cont) begin
				run_len = bump(run_len);
				return;
			end
			res[n].kind = (scan_mode == SCAN_NUMBER) ? KIND_NUMBER : KIND_IDENT;
			res[n].length = run_len;
			res[n].blanks = tok_blanks;
			res[n].last = 1'b0;
			n++;
			scan_mode = SCAN_IDLE;
			run_len = 8'd0;
			tok_blanks = 8'd0;
		end
		if (c == CH_SPACE || c == CH_TAB) begin
			blank_cnt = bump(blank_cnt);
		end else if (chr_digit(c) || chr_alpha(c) || chr_symbol(c)) begin
			scan_mode = chr_digit(c) ? SCAN_NUMBER : SCAN_IDENT;
			tok_blanks = blank_cnt;
			run_len = 8'd1;
			blank_cnt = 8'd0;
		end else begin
			if (c == CH_NUL)
				kind = KIND_END;
			else if (c == CH_OPEN)
				kind = KIND_OPEN;
			else if (c == CH_CLOSE)
				kind = KIND_CLOSE;
			else if (c == CH_LF)
				kind = KIND_NEWLINE;
			else
				kind = KIND_ILLEGAL;
			res[n].kind = kind;
			res[n].length = (kind == KIND_END) ? 8'd0 : 8'd1;
			res[n].blanks = blank_cnt;
			res[n].last = 1'b0;
			n++;
			blank_cnt = 8'd0;
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			token_q.push_back(res[i]);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 4);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		lex_byte(b);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Sends one random token; most are well formed, a few are arbitrary bytes.
	task automatic send_random_token();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			len = $urandom_range(1, 5);
			repeat (len) send_byte(rand_blank());
		end else if (pick < 35) begin
			len = $urandom_range(0, 6);
			send_byte(rand_digit());
			repeat (len) send_byte($urandom_range(0, 3) == 0 ? CH_DOT : rand_digit());
		end else if (pick < 65) begin
			len = $urandom_range(0, 7);
			send_byte($urandom_range(0, 1) ? rand_alpha() : rand_symbol());
			repeat (len) send_byte(rand_ident_char());
		end else if (pick < 73) begin
			send_byte(CH_OPEN);
		end else if (pick < 81) begin
			send_byte(CH_CLOSE);
		end else if (pick < 87) begin
			send_byte(CH_LF);
		end else if (pick < 91) begin
			send_byte(CH_NUL);
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed();
		logic [7:0] text [0:27];
		text = '{CH_TAB, CH_SPACE, "0", CH_DOT, "9", CH_OPEN,
			"A", "z", "9", CH_CLOSE, CH_LF,
			"!", "$", "%", "&", "*", "/", ":", "<", "=", ">", "~", "_", "^", "+", "-",
			CH_NUL, 8'hff};
		foreach (text[i])
			send_byte(text[i]);
		drain();
	endtask

	task automatic test_saturation();
		repeat (270) send_byte(rand_blank());
		send_byte(rand_digit());
		repeat (261) send_byte($urandom_range(0, 4) == 0 ? CH_DOT : rand_digit());
		send_byte(CH_SPACE);
		send_byte(rand_alpha());
		repeat (261) send_byte(rand_ident_char());
		send_byte(CH_NUL);
		drain();
	endtask

	task automatic test_backpressure();
		int start;
		steady = 1'b1;
		hold_req = 1'b1;
		start = bytes_sent;
		while (bytes_sent - start < 60)
			send_random_token();
		steady = 1'b0;
		drain();
	endtask

	task automatic test_random();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES)
			send_random_token();
		drain();
	endtask

	initial begin
		int phase_left;
		int style;
		m_tready = 1'b0;
		phase_left = 0;
		style = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (phase_left == 0) begin
					style = $urandom_range(0, 3);
					phase_left = $urandom_range(16, 80);
				end
				phase_left--;
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (phase_left % 3 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		clx_res_t got;
		clx_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tdata[2:0];
			got.length = m_tdata[10:3];
			got.blanks = m_tdata[18:11];
			got.last = m_tlast;
			if (token_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected token: kind %0d length %0d blanks %0d last %0b",
						got.kind, got.length, got.blanks, got.last);
			end else begin
				want = token_q.pop_front();
				tokens_seen++;
				if (got.kind !== want.kind || got.length !== want.length
						|| got.blanks !== want.blanks || got.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("Token %0d mismatch: expected kind %0d length %0d %s",
							tokens_seen, want.kind, want.length, "");
						$display("  blanks %0d last %0b, got kind %0d length %0d",
							want.blanks, want.last, got.kind, got.length);
						$display("  blanks %0d last %0b", got.blanks, got.last);
					end
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped at the cycle limit with %0d tokens outstanding.", token_q.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		scan_mode = SCAN_IDLE;
		blank_cnt = 8'd0;
		tok_blanks = 8'd0;
		run_len = 8'd0;
		bytes_sent = 0;
		tokens_seen = 0;
		fail_count = 0;
		burst_left = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_saturation();
		test_backpressure();
		test_random();
		if (token_q.size() != 0) begin
			fail_count++;
			$display("%0d expected tokens never arrived.", token_q.size());
		end
		$display("Streamed %0d text bytes and checked %0d tokens across every character class,",
			bytes_sent, tokens_seen);
		$display("saturated length and blank counts, and a long output stall.");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/clx_pkg.sv
rtl/clx_core.sv
rtl/clx_fifo.sv
rtl/calc_token_lexer.sv
tb/testbench.sv
